>>> hdl/bdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdf_pkg: shared types and constants of the decimal digit formatter
// Item layouts, controller states and the command/status bundles between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package bdf_pkg;

    localparam int VALUE_W     = 32;
    localparam int FWIDTH_W    = 4;
    localparam int CHAR_W      = 6;
    localparam int POS_W       = 3;
    localparam int COUNT_W     = 4;
    localparam int DIGIT_W     = 4;
    localparam int BIT_CNT_W   = 5;

    localparam logic [CHAR_W-1:0]    CH_SPACE    = 6'd32;
    localparam logic [CHAR_W-1:0]    CH_ZERO     = 6'd48;
    localparam logic [DIGIT_W-1:0]   BCD_ADJ_MIN = 4'd5;
    localparam logic [DIGIT_W-1:0]   BCD_ADJ     = 4'd3;
    localparam logic [BIT_CNT_W-1:0] BIT_LAST    = 5'd31;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [FWIDTH_W-1:0] field_width;
        logic                align_right;
        logic                show_leading_zeros;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  character;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] char_count;
        logic               last;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic conv_last;
        logic emit_last;
        logic out_free;
    } sts_t;

endpackage

>>> hdl/bdf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdf_if: valid/ready channels of the decimal digit formatter
// Input channel carries the value and format controls, output channel one
// ASCII character per item.
// ----------------------------------------------------------------------------
interface bdf_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic [3:0]  field_width;
    logic        align_right;
    logic        show_leading_zeros;

    modport source (output valid, value, field_width, align_right, show_leading_zeros,
                    input ready);
    modport sink   (input valid, value, field_width, align_right, show_leading_zeros,
                    output ready);
endinterface

interface bdf_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] character;
    logic [2:0] position;
    logic [3:0] char_count;
    logic       last;

    modport source (output valid, character, position, char_count, last, input ready);
    modport sink   (input valid, character, position, char_count, last, output ready);
endinterface

>>> hdl/bdf_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdf_dpath: formatter datapath
// Shift-add-3 binary to BCD converter kept to MAX_DIGITS digits, field
// bookkeeping and the output character register.
// ----------------------------------------------------------------------------
module bdf_dpath #(
    parameter int MAX_DIGITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bdf_pkg::in_item_t  in_item,
    input  bdf_pkg::cmd_t      cmd,
    input  logic               out_ready,
    output bdf_pkg::sts_t      sts,
    output logic               out_valid,
    output bdf_pkg::out_item_t out_item
);

    localparam int BCD_W = bdf_pkg::DIGIT_W * MAX_DIGITS;
    localparam logic [bdf_pkg::FWIDTH_W-1:0] MAX_W = bdf_pkg::FWIDTH_W'(MAX_DIGITS);

    logic [bdf_pkg::VALUE_W-1:0]   bin_reg, bin_next;
    logic [BCD_W-1:0]              bcd_reg, bcd_next;
    logic [bdf_pkg::BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [bdf_pkg::FWIDTH_W-1:0]  width_reg, width_next;
    logic                          right_reg, right_next;
    logic                          zeros_reg, zeros_next;
    logic [bdf_pkg::POS_W-1:0]     k_reg, k_next;
    logic                          out_valid_reg, out_valid_next;
    bdf_pkg::out_item_t            out_item_reg, out_item_next;

    logic [BCD_W-1:0]               bcd_adj;
    logic [bdf_pkg::DIGIT_W-1:0]    digit [MAX_DIGITS];
    logic [bdf_pkg::COUNT_W-1:0]    sig;
    logic [bdf_pkg::COUNT_W-1:0]    count;
    logic [bdf_pkg::COUNT_W-1:0]    lead;
    logic [bdf_pkg::COUNT_W-1:0]    idx;
    logic [bdf_pkg::DIGIT_W-1:0]    cur_digit;
    logic [bdf_pkg::CHAR_W-1:0]     cur_char;
    logic                           is_last;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (bcd_reg[i*bdf_pkg::DIGIT_W +: bdf_pkg::DIGIT_W] >= bdf_pkg::BCD_ADJ_MIN)
                bcd_adj[i*bdf_pkg::DIGIT_W +: bdf_pkg::DIGIT_W] =
                    bcd_reg[i*bdf_pkg::DIGIT_W +: bdf_pkg::DIGIT_W] + bdf_pkg::BCD_ADJ;
            else
                bcd_adj[i*bdf_pkg::DIGIT_W +: bdf_pkg::DIGIT_W] =
                    bcd_reg[i*bdf_pkg::DIGIT_W +: bdf_pkg::DIGIT_W];
        end
    end

    // digits beyond the field width drop out (value modulo ten to the width)
    always_comb
    begin
        sig = bdf_pkg::COUNT_W'(1);
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (bdf_pkg::FWIDTH_W'(i) < width_reg)
                digit[i] = bcd_reg[i*bdf_pkg::DIGIT_W +: bdf_pkg::DIGIT_W];
            else
                digit[i] = '0;
            if (digit[i] != '0)
                sig = bdf_pkg::COUNT_W'(i + 1);
        end
    end

    always_comb
    begin
        lead      = (zeros_reg || right_reg) ? width_reg : sig;
        count     = lead;
        idx       = lead - bdf_pkg::COUNT_W'(1) - {1'b0, k_reg};
        cur_digit = '0;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (idx == bdf_pkg::COUNT_W'(i))
                cur_digit = digit[i];
        end
        if (!zeros_reg && right_reg && idx >= sig)
            cur_char = bdf_pkg::CH_SPACE;
        else
            cur_char = bdf_pkg::CH_ZERO + {2'b00, cur_digit};
        is_last = ({1'b0, k_reg} + bdf_pkg::COUNT_W'(1)) == count;
    end

    always_comb
    begin
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        width_next     = width_reg;
        right_next     = right_reg;
        zeros_next     = zeros_reg;
        k_next         = k_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg;

        if (out_ready)
            out_valid_next = 1'b0;

        if (cmd.load)
        begin
            bin_next     = in_item.value;
            bcd_next     = '0;
            bit_cnt_next = '0;
            k_next       = '0;
            right_next   = in_item.align_right;
            zeros_next   = in_item.show_leading_zeros;
            if (in_item.field_width == '0 || in_item.field_width > MAX_W)
                width_next = MAX_W;
            else
                width_next = in_item.field_width;
        end

        if (cmd.shift)
        begin
            {bcd_next, bin_next} = {bcd_adj[BCD_W-2:0], bin_reg, 1'b0};
            bit_cnt_next         = bit_cnt_reg + bdf_pkg::BIT_CNT_W'(1);
        end

        if (cmd.emit)
        begin
            out_item_next.character  = cur_char;
            out_item_next.position   = k_reg;
            out_item_next.char_count = count;
            out_item_next.last       = is_last;
            out_valid_next           = 1'b1;
            k_next                   = k_reg + bdf_pkg::POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
            k_reg         <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            bit_cnt_reg   <= bit_cnt_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg      <= bin_next;
        bcd_reg      <= bcd_next;
        width_reg    <= width_next;
        right_reg    <= right_next;
        zeros_reg    <= zeros_next;
        out_item_reg <= out_item_next;
    end

    assign sts.conv_last = (bit_cnt_reg == bdf_pkg::BIT_LAST);
    assign sts.emit_last = is_last;
    assign sts.out_free  = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_item      = out_item_reg;

endmodule

>>> hdl/bdf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdf_ctrl: formatter controller
// Sequences load, 32 conversion steps and the character emissions.
// ----------------------------------------------------------------------------
module bdf_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  bdf_pkg::sts_t sts,
    output logic          in_ready,
    output bdf_pkg::cmd_t cmd
);

    bdf_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bdf_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = bdf_pkg::ST_CONV;
            end
            bdf_pkg::ST_CONV:
            begin
                if (sts.conv_last)
                    state_next = bdf_pkg::ST_EMIT;
            end
            bdf_pkg::ST_EMIT:
            begin
                if (sts.out_free && sts.emit_last)
                    state_next = bdf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bdf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        cmd       = '0;
        case (state_reg)
            bdf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            bdf_pkg::ST_CONV:
            begin
                cmd.shift = 1'b1;
            end
            bdf_pkg::ST_EMIT:
            begin
                cmd.emit = sts.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bdf_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> hdl/binary_to_decimal_digit_formatter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_digit_formatter_unit: 32-bit binary to ASCII decimal field
// Converts a value to BCD, keeps the low field-width digits and streams the
// formatted field out one character at a time.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake       payload
//  -------  ---  --------------  ---------------------------------------------
//  in_ch    in   valid / ready   value, field_width, align_right,
//                                show_leading_zeros
//  out_ch   out  valid / ready   character, position, char_count, last
//
//  Steps: the item is taken, the converter runs 32 shift-add-3 steps, then
//  the field goes out one character per cycle while out_ch is ready.
//  The 32-step converter loop takes the bulk of the time per item.
//  Reset: rst_n clears the controller and the output valid; no clearing pass.
//  Stalls: a held output character stalls emission only; the next item is
//  taken while the last character of a field still waits on out_ch.
//
module binary_to_decimal_digit_formatter_unit #(
    parameter int MAX_DIGITS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    bdf_in_if.sink     in_ch,
    bdf_out_if.source  out_ch
);

    bdf_pkg::in_item_t  in_item;
    bdf_pkg::out_item_t out_item;
    bdf_pkg::cmd_t      cmd;
    bdf_pkg::sts_t      sts;
    logic               out_valid;
    logic               in_ready;

    // gather the input fields into one item
    assign in_item.value              = in_ch.value;
    assign in_item.field_width        = in_ch.field_width;
    assign in_item.align_right        = in_ch.align_right;
    assign in_item.show_leading_zeros = in_ch.show_leading_zeros;
    assign in_ch.ready                = in_ready;

    bdf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .sts      (sts),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    bdf_dpath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

    // drive the output channel straight from the output register
    assign out_ch.valid      = out_valid;
    assign out_ch.character  = out_item.character;
    assign out_ch.position   = out_item.position;
    assign out_ch.char_count = out_item.char_count;
    assign out_ch.last       = out_item.last;

    // a taken item keeps the input closed while it converts
    a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("input accepted again right after a load");

    // never overwrite a character that is still waiting
    a_emit_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("emission into an occupied output register");

    // the final character sits at the end of the field
    a_last_position: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.last |->
            out_ch.position == 3'(out_ch.char_count - 4'd1))
        else $error("last flag away from the end of the field");

    // a field still being emitted keeps the next item out
    a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.last |-> !in_ch.ready)
        else $error("input open in the middle of a field");

endmodule

>>> tb/binary_to_decimal_digit_formatter_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_digit_formatter_unit_test: self-checking bench
// Sends values with field widths and format flags into the formatter, builds
// the expected character stream of each field in the bench itself, and
// compares each character the block delivers against it, field by field.
// Both channels idle at random in several phases.
// ----------------------------------------------------------------------------
module binary_to_decimal_digit_formatter_unit_test;

    localparam int FIELD_MAX   = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 60;

    logic clk;
    logic rst_n;

    bdf_in_if  in_ch ();
    bdf_out_if out_ch ();

    binary_to_decimal_digit_formatter_unit #(
        .MAX_DIGITS (FIELD_MAX)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Characters still owed by the block, oldest first.
    bdf_pkg::out_item_t expected_chars[$];

    int error_count   = 0;
    int fields_sent   = 0;
    int chars_checked = 0;
    int spaces_seen   = 0;
    int cycle_count   = 0;

    // Idle rates in percent; changed by the tests between phases.
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Expected field: clamp the width, keep the low width decimal digits,
    // then lay the characters out most significant first. With zeros shown
    // or right alignment the field is width long; otherwise only the
    // significant digits go out, and a zero still yields one '0'.
    // ------------------------------------------------------------------------
    function automatic void format_field(bdf_pkg::in_item_t it);
        int unsigned        width;
        int unsigned        sig;
        int unsigned        count;
        int unsigned        i;
        logic [63:0]        scale;
        logic [63:0]        rest;
        logic [3:0]         digit [FIELD_MAX];
        bdf_pkg::out_item_t ch;

        width = (it.field_width == 0 || it.field_width > FIELD_MAX)
                ? FIELD_MAX : it.field_width;
        scale = 1;
        for (i = 0; i < width; i++)
            scale = scale * 10;
        rest = 64'(it.value) % scale;

        sig = 1;
        for (i = 0; i < width; i++)
        begin
            digit[i] = 4'(rest % 10);
            rest     = rest / 10;
            if (digit[i] != 0)
                sig = i + 1;
        end

        if (it.show_leading_zeros || it.align_right)
            count = width;
        else
            count = sig;

        // Digit index i-1 runs from the top of the field down; anything
        // above the significant digits is padding unless zeros are shown.
        for (i = count; i > 0; i--)
        begin
            if (!it.show_leading_zeros && (i - 1) >= sig)
                ch.character = bdf_pkg::CH_SPACE;
            else
                ch.character = bdf_pkg::CH_ZERO + bdf_pkg::CHAR_W'(digit[i - 1]);
            ch.position   = bdf_pkg::POS_W'(count - i);
            ch.char_count = bdf_pkg::COUNT_W'(count);
            ch.last       = (i == 1);
            expected_chars.push_back(ch);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Send one item. Idle first at the sender's rate, then hold valid and
    // the payload until the block takes the item. Valid is left high so
    // that the next item can follow back to back.
    // ------------------------------------------------------------------------
    task automatic send_field(logic [31:0] value, logic [3:0] field_width,
                              logic align_right, logic show_leading_zeros);
        bdf_pkg::in_item_t it;

        it.value              = value;
        it.field_width        = field_width;
        it.align_right        = align_right;
        it.show_leading_zeros = show_leading_zeros;

        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid              <= 1'b1;
        in_ch.value              <= it.value;
        in_ch.field_width        <= it.field_width;
        in_ch.align_right        <= it.align_right;
        in_ch.show_leading_zeros <= it.show_leading_zeros;
        do
            @(posedge clk);
        while (!in_ch.ready);

        format_field(it);
        fields_sent++;
    endtask

    function automatic void compare_field(string name, int unsigned want,
                                          int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            error_count++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Output side: sample at the edge, check each accepted character against
    // the oldest expectation, then pick ready for the next cycle.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_chars
        bdf_pkg::out_item_t want;

        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_chars.size() == 0)
            begin
                $display("%0t: character %0d at position %0d with no field pending",
                         $time, out_ch.character, out_ch.position);
                error_count++;
            end
            else
            begin
                want = expected_chars.pop_front();
                compare_field("character",  want.character,  out_ch.character);
                compare_field("position",   want.position,   out_ch.position);
                compare_field("char_count", want.char_count, out_ch.char_count);
                compare_field("last",       want.last,       out_ch.last);
                chars_checked++;
                if (want.character == bdf_pkg::CH_SPACE)
                    spaces_seen++;
            end
        end
        out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Watchdog: stop a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d characters still owed",
                     $time, cycle_count, expected_chars.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Directed: field width extremes (zero, full, clamped 9 and 15, one
    // digit) against the smallest and largest values and all flag mixes.
    // ------------------------------------------------------------------------
    task automatic test_width_extremes();
        send_field(32'd0,          4'd0,  1'b0, 1'b0);
        send_field(32'd0,          4'd8,  1'b1, 1'b0);
        send_field(32'd0,          4'd3,  1'b0, 1'b1);
        send_field(32'hFFFF_FFFF,  4'd0,  1'b0, 1'b1);
        send_field(32'hFFFF_FFFF,  4'd15, 1'b1, 1'b0);
        send_field(32'hFFFF_FFFF,  4'd9,  1'b0, 1'b0);
        send_field(32'hFFFF_FFFF,  4'd1,  1'b0, 1'b0);
        send_field(32'd99999999,   4'd8,  1'b0, 1'b0);
        send_field(32'd7,          4'd1,  1'b1, 1'b1);
        send_field(32'h8000_0000,  4'd12, 1'b1, 1'b0);
        send_field(32'h5A5A_5A5A,  4'd7,  1'b0, 1'b1);
        send_field(32'hA5A5_A5A5,  4'd14, 1'b0, 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Directed: values that reduce to zero or lose high digits to the field,
    // and inner zeros that must not be taken for leading ones.
    // ------------------------------------------------------------------------
    task automatic test_zero_and_truncation();
        send_field(32'd100000000,  4'd8,  1'b0, 1'b0);
        send_field(32'd100000000,  4'd8,  1'b1, 1'b0);
        send_field(32'd12345,      4'd4,  1'b1, 1'b0);
        send_field(32'd12345,      4'd10, 1'b1, 1'b0);
        send_field(32'd1000,       4'd3,  1'b0, 1'b1);
        send_field(32'd1000,       4'd3,  1'b1, 1'b0);
        send_field(32'd1050,       4'd8,  1'b1, 1'b1);
        send_field(32'd1050,       4'd6,  1'b0, 1'b0);
        send_field(32'd9,          4'd2,  1'b1, 1'b0);
        send_field(32'd90,         4'd2,  1'b0, 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Random fields under a given pair of idle rates. Values mix full-range
    // words, short numbers, numbers with scattered zero digits, exact
    // multiples of the largest field and words near the top of the range.
    // ------------------------------------------------------------------------
    task automatic test_random_fields(int items, int src_pct, int sink_pct);
        logic [31:0] value;
        logic [31:0] scale;
        logic [3:0]  field_width;
        int          pick;
        int          k;
        int          j;

        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        repeat (items)
        begin
            pick = $urandom_range(9);
            if (pick <= 3)
                value = $urandom;
            else if (pick <= 6)
            begin
                k     = $urandom_range(8);
                scale = 1;
                for (j = 0; j < k; j++)
                    scale = scale * 10;
                value = $urandom % scale;
            end
            else if (pick == 7)
            begin
                value = 0;
                for (j = 0; j < FIELD_MAX; j++)
                    value = value * 10
                            + (($urandom_range(2) == 0) ? $urandom_range(9) : 0);
            end
            else if (pick == 8)
                value = $urandom_range(42) * 100000000;
            else
                value = 32'hFFFF_FFFF - $urandom_range(255);

            pick = $urandom_range(9);
            if (pick == 0)
                field_width = 4'd0;
            else if (pick == 1)
                field_width = 4'($urandom_range(15, 9));
            else
                field_width = 4'($urandom_range(8, 1));

            send_field(value, field_width, 1'($urandom), 1'($urandom));
        end
    endtask

    initial
    begin
        rst_n                    <= 1'b0;
        in_ch.valid              <= 1'b0;
        in_ch.value              <= '0;
        in_ch.field_width        <= '0;
        in_ch.align_right        <= 1'b0;
        in_ch.show_leading_zeros <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items go back to back with a mostly ready receiver.
        sink_idle_pct = 10;
        test_width_extremes();
        test_zero_and_truncation();

        // Random phases: slow sender with a stalling receiver, then the
        // other way round, then both at full rate.
        test_random_fields(66, 36, 60);
        test_random_fields(66, 60, 36);
        test_random_fields(66, 0, 0);

        // Drop valid, let the last fields drain, then keep the clock running
        // for anything the block might still emit.
        in_ch.valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Formatted %0d fields (widths 0 to 15, all flag mixes, idle phases).",
                 fields_sent);
        $display("Checked %0d characters, %0d of them padding spaces.",
                 chars_checked, spaces_seen);
        if (error_count == 0 && expected_chars.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
hdl/bdf_pkg.sv
hdl/bdf_if.sv
hdl/bdf_dpath.sv
hdl/bdf_ctrl.sv
hdl/binary_to_decimal_digit_formatter_unit.sv
tb/binary_to_decimal_digit_formatter_unit_test.sv
